// ===== rtl/rrs_pkg.sv =====
// Shared constants, job record type and sequencer states of the round robin scheduler.
`default_nettype none
package rrs_pkg;

    localparam int MAX_JOBS  = 64;
    localparam int JOB_IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int JOB_CNT_W = $clog2(MAX_JOBS + 1);
    localparam int TIME_W    = 16;
    localparam int CLK_W     = 24;
    localparam int NUM_W     = 7;

    localparam logic [TIME_W-1:0] QUANTUM_RESET = 16'd4;

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remaining;
        logic [NUM_W-1:0]  number;
        logic [CLK_W-1:0]  finish;
    } job_rec_t;

    typedef struct packed {
        logic load;
        logic last;
    } out_req_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RDI,
        ST_SORT_LDI,
        ST_SORT_RDJ,
        ST_SORT_CMP,
        ST_SORT_WRI,
        ST_SCH_INIT,
        ST_SCH_RD,
        ST_SCH_UPD,
        ST_SCH_END,
        ST_OUT_RD,
        ST_OUT_PUSH
    } rrs_state_t;

endpackage
`default_nettype wire

// ===== rtl/round_robin_schedule_sim.sv =====
// Top level of the round robin scheduler: job store, sort and schedule sequencer, result port.
//
// Jobs load at one item per cycle into a simple dual-port job memory (one write and one
// registered read a cycle). The item marked last, or the item that fills all 64 entries,
// starts the run, and the input stalls until the final result has moved into the result
// register. An exchange sort by arrival then runs: each outer pass reads and holds entry i,
// reads and compares each later entry j, swapping when the held entry arrives later, and
// writes the held entry back to i. Scheduling then scans the store, reading and updating
// each entry; the number of scans follows the data (roughly the largest burst over the
// quantum), and a scan that finds no job ready moves the clock straight to the next arrival.
// Results leave one at a time, read from the store and loaded into the result register when
// it is free. All three phases follow the registered memory read and each entry's read-modify-write.
`default_nettype none
module round_robin_schedule_sim (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_arrival_time,
    input  wire logic [15:0] s_burst_time,
    input  wire logic        s_last_job,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [6:0]       m_job_number,
    output logic [23:0]      m_completion_time,
    output logic [23:0]      m_turnaround_time,
    output logic [23:0]      m_waiting_time,
    output logic             m_last_result
);
    import rrs_pkg::*;

    rrs_state_t state_reg, state_next;

    logic [TIME_W-1:0]    quantum_reg, quantum_next;
    logic [JOB_CNT_W-1:0] job_count_reg, job_count_next;
    logic [JOB_CNT_W-1:0] n_reg, n_next;
    logic [JOB_IDX_W-1:0] last_idx_reg, last_idx_next;
    logic [JOB_IDX_W-1:0] i_reg, i_next;
    logic [JOB_IDX_W-1:0] j_reg, j_next;
    logic [JOB_IDX_W-1:0] k_reg, k_next;
    job_rec_t             hold_reg, hold_next;
    logic [CLK_W-1:0]     clock_reg, clock_next;
    logic [JOB_CNT_W-1:0] done_count_reg, done_count_next;
    logic                 ran_reg, ran_next;
    logic [TIME_W-1:0]    min_arr_reg, min_arr_next;

    logic                 wr_en;
    logic [JOB_IDX_W-1:0] wr_addr;
    job_rec_t             wr_data;
    logic [JOB_IDX_W-1:0] rd_addr;
    job_rec_t             rd_data;

    logic                 load_final;
    logic [TIME_W-1:0]    burst_fix;
    logic [TIME_W-1:0]    q_eff;
    logic                 job_ready;
    logic [CLK_W-1:0]     clock_plus_q;
    logic [CLK_W-1:0]     clock_plus_rem;
    job_rec_t             new_rec;
    job_rec_t             upd_rec;
    out_req_t             out_req;
    logic                 can_load;

    rrs_job_ram #(
        .WIDTH ($bits(job_rec_t)),
        .DEPTH (MAX_JOBS)
    ) u_job_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rrs_out_stage u_out_stage (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .req               (out_req),
        .rec               (rd_data),
        .can_load          (can_load),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_job_number      (m_job_number),
        .m_completion_time (m_completion_time),
        .m_turnaround_time (m_turnaround_time),
        .m_waiting_time    (m_waiting_time),
        .m_last_result     (m_last_result)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_LOAD);

    always_comb begin
        load_final = s_last_job ||
                     (JOB_CNT_W'(job_count_reg + 1'b1) == JOB_CNT_W'(MAX_JOBS));
        burst_fix  = (s_burst_time == '0) ? TIME_W'(1) : s_burst_time;
        q_eff      = (quantum_reg == '0) ? TIME_W'(1) : quantum_reg;
        job_ready  = (rd_data.remaining != '0) &&
                     ({{(CLK_W-TIME_W){1'b0}}, rd_data.arrival} <= clock_reg);
        clock_plus_q   = clock_reg + {{(CLK_W-TIME_W){1'b0}}, q_eff};
        clock_plus_rem = clock_reg + {{(CLK_W-TIME_W){1'b0}}, rd_data.remaining};
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid && load_final) begin
                    state_next = (job_count_reg == '0) ? ST_SCH_INIT : ST_SORT_RDI;
                end
            end
            ST_SORT_RDI: state_next = ST_SORT_LDI;
            ST_SORT_LDI: state_next = ST_SORT_RDJ;
            ST_SORT_RDJ: state_next = ST_SORT_CMP;
            ST_SORT_CMP: begin
                state_next = (j_reg == last_idx_reg) ? ST_SORT_WRI : ST_SORT_RDJ;
            end
            ST_SORT_WRI: begin
                state_next = (JOB_IDX_W'(i_reg + 1'b1) == last_idx_reg) ?
                             ST_SCH_INIT : ST_SORT_RDI;
            end
            ST_SCH_INIT: state_next = ST_SCH_RD;
            ST_SCH_RD:   state_next = ST_SCH_UPD;
            ST_SCH_UPD: begin
                state_next = (i_reg == last_idx_reg) ? ST_SCH_END : ST_SCH_RD;
            end
            ST_SCH_END: begin
                state_next = (done_count_reg == n_reg) ? ST_OUT_RD : ST_SCH_RD;
            end
            ST_OUT_RD: state_next = ST_OUT_PUSH;
            ST_OUT_PUSH: begin
                if (can_load) begin
                    state_next = (k_reg == last_idx_reg) ? ST_LOAD : ST_OUT_RD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        quantum_next    = quantum_reg;
        job_count_next  = job_count_reg;
        n_next          = n_reg;
        last_idx_next   = last_idx_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        hold_next       = hold_reg;
        clock_next      = clock_reg;
        done_count_next = done_count_reg;
        ran_next        = ran_reg;
        min_arr_next    = min_arr_reg;
        wr_en           = 1'b0;
        wr_addr         = i_reg;
        wr_data         = hold_reg;
        rd_addr         = i_reg;
        out_req         = '0;

        new_rec.arrival   = s_arrival_time;
        new_rec.burst     = burst_fix;
        new_rec.remaining = burst_fix;
        new_rec.number    = NUM_W'(job_count_reg + 1'b1);
        new_rec.finish    = '0;

        upd_rec = rd_data;

        if (cfg_valid) begin
            quantum_next = cfg_data;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    wr_en   = 1'b1;
                    wr_addr = job_count_reg[JOB_IDX_W-1:0];
                    wr_data = new_rec;
                    if (load_final) begin
                        job_count_next = '0;
                        n_next         = JOB_CNT_W'(job_count_reg + 1'b1);
                        last_idx_next  = job_count_reg[JOB_IDX_W-1:0];
                        i_next         = '0;
                    end else begin
                        job_count_next = JOB_CNT_W'(job_count_reg + 1'b1);
                    end
                end
            end
            ST_SORT_RDI: begin
                rd_addr = i_reg;
            end
            ST_SORT_LDI: begin
                hold_next = rd_data;
                j_next    = JOB_IDX_W'(i_reg + 1'b1);
            end
            ST_SORT_RDJ: begin
                rd_addr = j_reg;
            end
            ST_SORT_CMP: begin
                // swap: entry j takes the held entry, the held entry becomes j
                if (hold_reg.arrival > rd_data.arrival) begin
                    wr_en     = 1'b1;
                    wr_addr   = j_reg;
                    wr_data   = hold_reg;
                    hold_next = rd_data;
                end
                j_next = JOB_IDX_W'(j_reg + 1'b1);
            end
            ST_SORT_WRI: begin
                wr_en   = 1'b1;
                wr_addr = i_reg;
                wr_data = hold_reg;
                i_next  = JOB_IDX_W'(i_reg + 1'b1);
            end
            ST_SCH_INIT: begin
                clock_next      = '0;
                done_count_next = '0;
                i_next          = '0;
                ran_next        = 1'b0;
                min_arr_next    = '1;
            end
            ST_SCH_RD: begin
                rd_addr = i_reg;
            end
            ST_SCH_UPD: begin
                if (job_ready) begin
                    ran_next = 1'b1;
                    wr_en    = 1'b1;
                    wr_addr  = i_reg;
                    if (rd_data.remaining > q_eff) begin
                        clock_next        = clock_plus_q;
                        upd_rec.remaining = rd_data.remaining - q_eff;
                    end else begin
                        clock_next        = clock_plus_rem;
                        upd_rec.remaining = '0;
                        upd_rec.finish    = clock_plus_rem;
                        done_count_next   = JOB_CNT_W'(done_count_reg + 1'b1);
                    end
                    wr_data = upd_rec;
                end else if (rd_data.remaining != '0 && rd_data.arrival < min_arr_reg) begin
                    min_arr_next = rd_data.arrival;
                end
                i_next = JOB_IDX_W'(i_reg + 1'b1);
            end
            ST_SCH_END: begin
                // after an idle scan the clock jumps straight to the next arrival
                if (!ran_reg) begin
                    clock_next = {{(CLK_W-TIME_W){1'b0}}, min_arr_reg};
                end
                ran_next     = 1'b0;
                min_arr_next = '1;
                i_next       = '0;
                k_next       = '0;
            end
            ST_OUT_RD: begin
                rd_addr = k_reg;
            end
            ST_OUT_PUSH: begin
                // hold the read address so the record stays on the read port
                rd_addr      = k_reg;
                out_req.load = can_load;
                out_req.last = (k_reg == last_idx_reg);
                if (can_load) begin
                    k_next = JOB_IDX_W'(k_reg + 1'b1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            quantum_reg    <= QUANTUM_RESET;
            job_count_reg  <= '0;
            clock_reg      <= '0;
            done_count_reg <= '0;
            n_reg          <= '0;
            last_idx_reg   <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            ran_reg        <= 1'b0;
            min_arr_reg    <= '1;
        end else begin
            state_reg      <= state_next;
            quantum_reg    <= quantum_next;
            job_count_reg  <= job_count_next;
            clock_reg      <= clock_next;
            done_count_reg <= done_count_next;
            n_reg          <= n_next;
            last_idx_reg   <= last_idx_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            ran_reg        <= ran_next;
            min_arr_reg    <= min_arr_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
    end

`ifndef SYNTHESIS
    a_done_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCH_UPD || state_reg == ST_SCH_END) |-> done_count_reg <= n_reg)
        else $error("finished job count exceeds the job count");

    a_clock_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCH_RD || state_reg == ST_SCH_UPD || state_reg == ST_SCH_END) &&
         ($past(state_reg) == ST_SCH_RD || $past(state_reg) == ST_SCH_UPD ||
          $past(state_reg) == ST_SCH_END))
        |-> clock_reg >= $past(clock_reg))
        else $error("simulated clock moved backwards");

    a_final_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && load_final) |=> !s_ready)
        else $error("input taken after the final job of a set");

    a_out_after_schedule: assert property (@(posedge aclk) disable iff (!aresetn)
        out_req.load |-> done_count_reg == n_reg)
        else $error("result issued before all jobs finished");
`endif

endmodule
`default_nettype wire

// ===== rtl/rrs_job_ram.sv =====
// Generic single write, single read RAM with a registered read port.
`default_nettype none
module rrs_job_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/rrs_out_stage.sv =====
// Result register: derives turnaround and waiting times and holds the item until taken.
`default_nettype none
module rrs_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rrs_pkg::out_req_t req,
    input  wire rrs_pkg::job_rec_t rec,
    output logic                   can_load,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [6:0]             m_job_number,
    output logic [23:0]            m_completion_time,
    output logic [23:0]            m_turnaround_time,
    output logic [23:0]            m_waiting_time,
    output logic                   m_last_result
);
    import rrs_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [CLK_W-1:0] tat;
    logic [CLK_W-1:0] wt;

    assign can_load = !valid_reg || m_ready;

    always_comb begin
        tat = rec.finish - {{(CLK_W-TIME_W){1'b0}}, rec.arrival};
        wt  = tat - {{(CLK_W-TIME_W){1'b0}}, rec.burst};
    end

    always_comb begin
        valid_next = valid_reg;
        if (req.load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.load) begin
            m_job_number      <= rec.number;
            m_completion_time <= rec.finish;
            m_turnaround_time <= tat;
            m_waiting_time    <= wt;
            m_last_result     <= req.last;
        end
    end

    assign m_valid = valid_reg;

endmodule
`default_nettype wire
